// ----- rtl/assert_macros.svh -----
// assert_macros.svh: assertion macros used by the checker file cse_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/cse_pkg.sv -----
// cse_pkg: codes, widths and request/result types of the call-stack profiler.
// No dependencies.
package cse_pkg;

    localparam int ID_W        = 6;
    localparam int TS_W        = 32;
    localparam int LAST_W      = 33;
    localparam int TOTAL_W     = 32;
    localparam int DEPTH_OUT_W = 7;
    localparam int ACT_W       = 7;

    localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_ENTER = 2'd0,
        CMD_EXIT  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_RANGE = 3'd3,
        ST_BACK  = 3'd4
    } t_status;

    // classified request, front to back
    typedef struct packed {
        t_cmd             cmd;
        logic             id_ok;
        logic [ID_W-1:0]  id;
        logic [TS_W-1:0]  ts;
    } t_req;

    typedef struct packed {
        t_status                status;
        logic                   charged;
        logic [ID_W-1:0]        charged_id;
        logic [LAST_W-1:0]      amount;
        logic [TOTAL_W-1:0]     total;
        logic [DEPTH_OUT_W-1:0] depth;
    } t_result;

endpackage

// ----- rtl/cse_front.sv -----
// cse_front: accepts requests, holds the active_functions register and
// range-checks ids. Depends on cse_pkg.
module cse_front #(
    parameter int NUM_FUNCS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [1:0]                i_s_tuser,   // cmd
    input  logic [39:0]               i_s_tdata,   // func_id, timestamp
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [cse_pkg::ACT_W-1:0] i_cfg_data,
    input  logic                      i_q_full,
    input  logic                      i_clearing,
    output logic                      o_q_push,
    output cse_pkg::t_req             o_q_req
);

    logic [cse_pkg::ACT_W-1:0] r_active;
    logic [cse_pkg::ID_W-1:0]  id;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !i_q_full && !i_clearing;
    assign o_q_push    = i_s_tvalid && o_s_tready;

    assign id = i_s_tdata[cse_pkg::ID_W-1:0];

    always_comb begin
        o_q_req.cmd   = cse_pkg::t_cmd'(i_s_tuser);
        o_q_req.id    = id;
        o_q_req.ts    = i_s_tdata[cse_pkg::ID_W +: cse_pkg::TS_W];
        o_q_req.id_ok = ({1'b0, id} < r_active) && (int'(id) < NUM_FUNCS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= cse_pkg::ACTIVE_RESET;
        end else if (i_cfg_valid) begin
            r_active <= i_cfg_data;
        end
    end

endmodule

// ----- rtl/cse_queue.sv -----
// cse_queue: two-entry request queue between front and back.
// Depends on cse_pkg.
module cse_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cse_pkg::t_req i_req,
    output logic          o_full,
    input  logic          i_pop,
    output cse_pkg::t_req o_req,
    output logic          o_empty
);

    cse_pkg::t_req r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/cse_back.sv -----
// cse_back: stack, exclusive totals and the two-step execute sequencer with
// the result register. Depends on cse_pkg.
module cse_back #(
    parameter int STACK_DEPTH = 64,
    parameter int NUM_FUNCS   = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  cse_pkg::t_req    i_q_req,
    output logic             o_q_pop,
    output logic             o_clearing,
    output logic             o_res_valid,
    output cse_pkg::t_result o_res,
    input  logic             i_res_ready
);

    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int FW = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
    localparam int IW = (FW > cse_pkg::ID_W) ? FW : cse_pkg::ID_W;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} t_state;

    function automatic logic [FW-1:0] idx_of(input logic [cse_pkg::ID_W-1:0] id);
        logic [IW-1:0] e;
        e = IW'(id);
        return e[FW-1:0];
    endfunction

    t_state                          r_state;
    logic [FW-1:0]                   r_clr_idx;
    logic [PW-1:0]                   r_sp;
    logic [cse_pkg::LAST_W-1:0]      r_last;
    logic [cse_pkg::ID_W-1:0]        r_top;
    cse_pkg::t_req                   r_req;
    cse_pkg::t_status                r_status;
    logic                            r_charge;
    logic                            r_push;
    logic                            r_pop;
    logic [cse_pkg::LAST_W-1:0]      r_amount;
    logic [cse_pkg::LAST_W-1:0]      r_new_last;
    logic                            r_out_valid;
    cse_pkg::t_result                r_out;

    logic [cse_pkg::ID_W-1:0]        r_stack [STACK_DEPTH];
    logic [cse_pkg::ID_W-1:0]        r_stack_rd;
    logic [cse_pkg::TOTAL_W-1:0]     r_totals [NUM_FUNCS];
    logic [cse_pkg::TOTAL_W-1:0]     r_tot_rd;

    // issue-step decode
    logic [cse_pkg::LAST_W-1:0]      ts33, ts_p1;
    cse_pkg::t_status                n_status;
    logic                            n_charge, n_push, n_pop;
    logic [cse_pkg::LAST_W-1:0]      n_new_last;
    logic [FW-1:0]                   tot_raddr;
    logic [PW-1:0]                   sp_m2, sp_m1;
    // execute step
    logic [cse_pkg::LAST_W:0]        sum;
    logic [cse_pkg::TOTAL_W-1:0]     sat;
    logic [PW-1:0]                   n_sp;
    logic                            tot_we;
    logic [FW-1:0]                   tot_waddr;
    logic [cse_pkg::TOTAL_W-1:0]     tot_wdata;
    logic                            stk_we;

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty && (!r_out_valid || i_res_ready);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    assign ts33  = {1'b0, i_q_req.ts};
    assign ts_p1 = ts33 + cse_pkg::LAST_W'(1);
    assign sp_m2 = r_sp - PW'(2);
    assign sp_m1 = r_sp - PW'(1);

    always_comb begin
        n_status   = cse_pkg::ST_OK;
        n_charge   = 1'b0;
        n_push     = 1'b0;
        n_pop      = 1'b0;
        n_new_last = (i_q_req.cmd == cse_pkg::CMD_EXIT) ? ts_p1 : ts33;
        tot_raddr  = (i_q_req.cmd == cse_pkg::CMD_READ) ? idx_of(i_q_req.id) : idx_of(r_top);
        unique case (i_q_req.cmd)
            cse_pkg::CMD_ENTER: begin
                priority if (!i_q_req.id_ok) begin
                    n_status = cse_pkg::ST_RANGE;
                end else if (ts33 < r_last) begin
                    n_status = cse_pkg::ST_BACK;
                end else if (r_sp == PW'(STACK_DEPTH)) begin
                    n_status = cse_pkg::ST_FULL;
                end else begin
                    n_push   = 1'b1;
                    n_charge = (r_sp != '0);
                end
            end
            cse_pkg::CMD_EXIT: begin
                priority if (!i_q_req.id_ok) begin
                    n_status = cse_pkg::ST_RANGE;
                end else if (r_sp == '0) begin
                    n_status = cse_pkg::ST_EMPTY;
                end else if (ts_p1 < r_last) begin
                    n_status = cse_pkg::ST_BACK;
                end else begin
                    n_pop    = 1'b1;
                    n_charge = 1'b1;
                end
            end
            cse_pkg::CMD_READ: begin
                if (!i_q_req.id_ok) begin
                    n_status = cse_pkg::ST_RANGE;
                end
            end
            default: begin
                n_status = cse_pkg::ST_OK;
            end
        endcase
    end

    // saturating add of the charge
    assign sum = {2'b00, r_tot_rd} + {1'b0, r_amount};
    assign sat = (sum[cse_pkg::LAST_W:cse_pkg::TOTAL_W] != '0) ? '1
                                                               : sum[cse_pkg::TOTAL_W-1:0];

    always_comb begin
        n_sp = r_sp;
        if (r_push) begin
            n_sp = r_sp + PW'(1);
        end else if (r_pop) begin
            n_sp = r_sp - PW'(1);
        end
    end

    assign tot_we    = (r_state == S_CLEAR) || ((r_state == S_EXEC) && r_charge);
    assign tot_waddr = (r_state == S_CLEAR) ? r_clr_idx : idx_of(r_top);
    assign tot_wdata = (r_state == S_CLEAR) ? '0 : sat;
    assign stk_we    = (r_state == S_EXEC) && r_push && (r_sp != '0);

    // memories: registered reads in the issue step, writes in execute/clear
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_stack_rd <= r_stack[sp_m2[SW-1:0]];
            r_tot_rd   <= r_totals[tot_raddr];
        end
        if (tot_we) begin
            r_totals[tot_waddr] <= tot_wdata;
        end
        if (stk_we) begin
            r_stack[sp_m1[SW-1:0]] <= r_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_sp        <= '0;
            r_last      <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + FW'(1);
                    if (r_clr_idx == FW'(NUM_FUNCS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_req      <= i_q_req;
                        r_status   <= n_status;
                        r_charge   <= n_charge;
                        r_push     <= n_push;
                        r_pop      <= n_pop;
                        r_amount   <= n_new_last - r_last;
                        r_new_last <= n_new_last;
                        r_state    <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_sp <= n_sp;
                    if (r_push) begin
                        r_top  <= r_req.id;
                        r_last <= r_new_last;
                    end else if (r_pop) begin
                        r_top  <= r_stack_rd;
                        r_last <= r_new_last;
                    end
                    r_out.status     <= r_status;
                    r_out.charged    <= r_charge;
                    r_out.charged_id <= r_charge ? r_top :
                                        (r_req.cmd == cse_pkg::CMD_READ) ? r_req.id : '0;
                    r_out.amount     <= r_charge ? r_amount : '0;
                    r_out.total      <= r_charge ? sat :
                                        ((r_req.cmd == cse_pkg::CMD_READ) &&
                                         (r_status == cse_pkg::ST_OK)) ? r_tot_rd : '0;
                    r_out.depth      <= cse_pkg::DEPTH_OUT_W'(n_sp);
                    r_state          <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (r_state == S_EXEC) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/call_stack_exclusive_time.sv -----
// Path: an accepted request passes the two-entry queue, the issue-step registers
//   and the result register. The back end takes a new request only after the last
//   one's issue step (stack and totals read) and read-modify-write of the totals memory.
// Reset: synchronous, active low; afterwards a clear pass zeroes the totals
//   memory, with o_s_tready low until it ends. Config writes always taken.
module call_stack_exclusive_time #(
    parameter int STACK_DEPTH = 64,
    parameter int NUM_FUNCS   = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request stream
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [1:0]                i_s_tuser,   // [1:0] cmd
    input  logic [39:0]               i_s_tdata,   // [5:0] func_id, [37:6] timestamp, pad
    // result stream
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [3:0]                o_m_tuser,   // [2:0] status, [3] charged
    output logic [79:0]               o_m_tdata,   // [5:0] charged_id, [38:6] charged_amount,
                                                   // [70:39] new_total, [77:71] stack_depth, pad
    // active_functions register write
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [cse_pkg::ACT_W-1:0] i_cfg_data
);

    // Front classifies (decode, id range vs active_functions) and queues; the
    // back end owns the stack pointer, top-of-stack register, stack memory
    // below the top, last switch time and the totals memory.
    cse_pkg::t_req    q_in_req;
    cse_pkg::t_req    q_out_req;
    cse_pkg::t_result res;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic             clearing;

    cse_front #(
        .NUM_FUNCS (NUM_FUNCS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .i_clearing  (clearing),
        .o_q_push    (q_push),
        .o_q_req     (q_in_req)
    );

    // two-entry request queue decouples acceptance from execution
    cse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_req   (q_in_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_req   (q_out_req),
        .o_empty (q_empty)
    );

    cse_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .NUM_FUNCS   (NUM_FUNCS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_req     (q_out_req),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_res_valid (o_m_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_tready)
    );

    // result packing, highest field first
    assign o_m_tuser = {res.charged, res.status};
    assign o_m_tdata = {2'b00, res.depth, res.total, res.amount, res.charged_id};

endmodule

// ----- rtl/cse_checker.sv -----
// cse_checker: port-level checks of the call-stack profiler, bound to the top.
// Depends on cse_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [3:0]  o_m_tuser,
    input logic [79:0] o_m_tdata
);

    logic        stalled;
    logic        res_ok;
    logic        res_empty;
    logic        res_charged;
    logic [32:0] res_amount;
    logic [6:0]  res_depth;
    logic [83:0] res_bits;

    assign stalled     = o_m_tvalid && !i_m_tready;
    assign res_ok      = (o_m_tuser[2:0] == cse_pkg::ST_OK);
    assign res_empty   = (o_m_tuser[2:0] == cse_pkg::ST_EMPTY);
    assign res_charged = o_m_tuser[3];
    assign res_amount  = o_m_tdata[38:6];
    assign res_depth   = o_m_tdata[77:71];
    assign res_bits    = {o_m_tuser, o_m_tdata};

    // stalled result holds
    `ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, stalled, o_m_tvalid && $stable(res_bits))

    // a flagged request never charges
    `ASSERT_IMPLIES(a_flag_no_charge, i_clk, i_rst_n, o_m_tvalid && !res_ok, !res_charged)

    // no charge means no amount
    `ASSERT_IMPLIES(a_no_charge_amount, i_clk, i_rst_n, o_m_tvalid && !res_charged, res_amount == '0)

    // exit on empty stack reports depth zero
    `ASSERT_IMPLIES(a_empty_depth, i_clk, i_rst_n, o_m_tvalid && res_empty, res_depth == '0)

endmodule

bind call_stack_exclusive_time cse_checker u_cse_checker (.*);
